/* rtl/core/pfa_pkg.sv */
package pfa_pkg;

  // Field and request widths
  localparam int ELEM_W = 30;
  localparam int EXP_W  = 63;
  localparam int KIND_W = 3;
  localparam int CNT_W  = $clog2(ELEM_W);

  // Prime modulus of the field
  localparam longint unsigned MODULUS_INT = 64'd1000000007;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [ELEM_W:0]   sum_t;
  typedef logic [ELEM_W+1:0] wide_t;
  typedef logic [EXP_W-1:0]  exp_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam elem_t MODULUS = elem_t'(MODULUS_INT);
  localparam sum_t  MOD_S   = sum_t'(MODULUS_INT);
  localparam wide_t MOD_X1  = wide_t'(MODULUS_INT);
  localparam wide_t MOD_X2  = wide_t'(2 * MODULUS_INT);
  localparam elem_t ONE     = elem_t'(1 % MODULUS_INT);
  // Fermat exponent: x^(p-2) is the inverse of x in a prime field
  localparam exp_t  INV_EXP = exp_t'(MODULUS_INT - 2);
  localparam cnt_t  CNT_LAST = cnt_t'(ELEM_W - 1);

  // Operation codes
  localparam kind_t KIND_ADD = kind_t'(0);
  localparam kind_t KIND_SUB = kind_t'(1);
  localparam kind_t KIND_MUL = kind_t'(2);
  localparam kind_t KIND_DIV = kind_t'(3);
  localparam kind_t KIND_POW = kind_t'(4);
  localparam kind_t KIND_INV = kind_t'(5);
  localparam kind_t KIND_NEG = kind_t'(6);

  typedef struct packed {
    kind_t kind;
    elem_t operand_a;
    elem_t operand_b;
    exp_t  exponent;
  } req_t;

  typedef struct packed {
    logic  start;
    elem_t x;
    elem_t y;
  } mul_cmd_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    elem_t product;
  } mul_sts_t;

  // Bring a raw operand below the modulus; one subtract covers the
  // whole 30-bit input range since 2^30 is below twice the modulus
  function automatic elem_t reduce(elem_t x);
    reduce = (x >= MODULUS) ? elem_t'(x - MODULUS) : x;
  endfunction

endpackage

/* rtl/core/pfa_req_if.sv */
interface pfa_req_if;
  logic            valid;
  logic            ready;
  pfa_pkg::kind_t  kind;
  pfa_pkg::elem_t  operand_a;
  pfa_pkg::elem_t  operand_b;
  pfa_pkg::exp_t   exponent;

  modport source (output valid, output kind, output operand_a, output operand_b,
                  output exponent, input ready);
  modport sink   (input valid, input kind, input operand_a, input operand_b,
                  input exponent, output ready);
endinterface

/* rtl/core/pfa_rsp_if.sv */
interface pfa_rsp_if;
  logic            valid;
  logic            ready;
  pfa_pkg::elem_t  result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

/* rtl/core/pfa_modmul.sv */
module pfa_modmul (
  input  logic              clk,
  input  logic              rst,
  input  pfa_pkg::mul_cmd_t cmd,
  output pfa_pkg::mul_sts_t sts
);

  logic              busy;
  logic              done;
  pfa_pkg::cnt_t     cnt;
  pfa_pkg::elem_t    acc;
  pfa_pkg::elem_t    xr;
  pfa_pkg::elem_t    yr;
  pfa_pkg::elem_t    product;
  pfa_pkg::wide_t    t;
  pfa_pkg::wide_t    t_red;
  pfa_pkg::elem_t    acc_next;

  // Double the partial sum, add x when the current bit of y is set,
  // then fold back below the modulus (sum stays under three moduli)
  always_comb begin
    t = {1'b0, acc, 1'b0} + {2'b00, (yr[pfa_pkg::ELEM_W-1] ? xr : '0)};
    if (t >= pfa_pkg::MOD_X2) begin
      t_red = t - pfa_pkg::MOD_X2;
    end else if (t >= pfa_pkg::MOD_X1) begin
      t_red = t - pfa_pkg::MOD_X1;
    end else begin
      t_red = t;
    end
    acc_next = pfa_pkg::elem_t'(t_red);
  end

  // Walk y from its top bit down, one bit per cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      acc  <= '0;
      xr   <= cmd.x;
      yr   <= cmd.y;
    end else if (busy) begin
      acc <= acc_next;
      yr  <= {yr[pfa_pkg::ELEM_W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
      if (cnt == pfa_pkg::CNT_LAST) begin
        busy    <= 1'b0;
        done    <= 1'b1;
        product <= acc_next;
      end
    end
  end

  assign sts.busy    = busy;
  assign sts.done    = done;
  assign sts.product = product;

endmodule

/* rtl/core/pfa_ctrl.sv */
module pfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  pfa_pkg::req_t     req_data,
  output logic              idle,
  input  logic              out_free,
  output logic              push,
  output pfa_pkg::elem_t    push_data,
  output pfa_pkg::mul_cmd_t mul_cmd,
  input  pfa_pkg::mul_sts_t mul_sts
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL     = 3'd1;
  localparam logic [2:0] S_POW_CHK = 3'd2;
  localparam logic [2:0] S_POW_ACC = 3'd3;
  localparam logic [2:0] S_POW_SQ  = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]      state;
  pfa_pkg::kind_t  kind;
  pfa_pkg::elem_t  a_r;
  pfa_pkg::elem_t  acc;
  pfa_pkg::elem_t  base;
  pfa_pkg::exp_t   e;
  pfa_pkg::elem_t  res;
  logic            mul_start;
  pfa_pkg::elem_t  mul_x;
  pfa_pkg::elem_t  mul_y;

  pfa_pkg::elem_t  in_a;
  pfa_pkg::elem_t  in_b;
  pfa_pkg::sum_t   sum;
  pfa_pkg::elem_t  add_res;
  pfa_pkg::elem_t  sub_res;
  pfa_pkg::elem_t  neg_res;

  function automatic pfa_pkg::sum_t sum_t_sub(pfa_pkg::elem_t x, pfa_pkg::elem_t y);
    sum_t_sub = {1'b0, x} + pfa_pkg::MOD_S - {1'b0, y};
  endfunction

  // Single-step operations on the reduced operands
  always_comb begin
    in_a = pfa_pkg::reduce(req_data.operand_a);
    in_b = pfa_pkg::reduce(req_data.operand_b);
    sum  = {1'b0, in_a} + {1'b0, in_b};
    add_res = (sum >= pfa_pkg::MOD_S) ? pfa_pkg::elem_t'(sum - pfa_pkg::MOD_S)
                                      : pfa_pkg::elem_t'(sum);
    sub_res = (in_a >= in_b) ? pfa_pkg::elem_t'(in_a - in_b)
                             : pfa_pkg::elem_t'(sum_t_sub(in_a, in_b));
    neg_res = (in_a == '0) ? '0 : pfa_pkg::elem_t'(pfa_pkg::MODULUS - in_a);
  end

  // Sequence each operation, running the shared multiplier for multiply, divide, power and inverse
  always_ff @(posedge clk) begin
    mul_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind <= req_data.kind;
            a_r  <= in_a;
            acc  <= pfa_pkg::ONE;
            case (req_data.kind)
              pfa_pkg::KIND_ADD: begin
                res   <= add_res;
                state <= S_DONE;
              end
              pfa_pkg::KIND_SUB: begin
                res   <= sub_res;
                state <= S_DONE;
              end
              pfa_pkg::KIND_NEG: begin
                res   <= neg_res;
                state <= S_DONE;
              end
              pfa_pkg::KIND_MUL: begin
                mul_start <= 1'b1;
                mul_x     <= in_a;
                mul_y     <= in_b;
                state     <= S_MUL;
              end
              pfa_pkg::KIND_POW: begin
                base  <= in_a;
                e     <= req_data.exponent;
                state <= S_POW_CHK;
              end
              pfa_pkg::KIND_INV: begin
                // inverse of zero is zero
                base  <= in_a;
                e     <= pfa_pkg::INV_EXP;
                res   <= '0;
                state <= (in_a == '0) ? S_DONE : S_POW_CHK;
              end
              pfa_pkg::KIND_DIV: begin
                // divide by zero yields zero
                base  <= in_b;
                e     <= pfa_pkg::INV_EXP;
                res   <= '0;
                state <= (in_b == '0) ? S_DONE : S_POW_CHK;
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          if (mul_sts.done) begin
            res   <= mul_sts.product;
            state <= S_DONE;
          end
        end
        S_POW_CHK: begin
          if (e == '0) begin
            if (kind == pfa_pkg::KIND_DIV) begin
              mul_start <= 1'b1;
              mul_x     <= a_r;
              mul_y     <= acc;
              state     <= S_MUL;
            end else begin
              res   <= acc;
              state <= S_DONE;
            end
          end else if (e[0]) begin
            mul_start <= 1'b1;
            mul_x     <= acc;
            mul_y     <= base;
            state     <= S_POW_ACC;
          end else begin
            mul_start <= 1'b1;
            mul_x     <= base;
            mul_y     <= base;
            state     <= S_POW_SQ;
          end
        end
        S_POW_ACC: begin
          if (mul_sts.done) begin
            acc <= mul_sts.product;
            // skip the final square when no exponent bits remain
            if (e[pfa_pkg::EXP_W-1:1] == '0) begin
              e     <= '0;
              state <= S_POW_CHK;
            end else begin
              mul_start <= 1'b1;
              mul_x     <= base;
              mul_y     <= base;
              state     <= S_POW_SQ;
            end
          end
        end
        S_POW_SQ: begin
          if (mul_sts.done) begin
            base  <= mul_sts.product;
            e     <= {1'b0, e[pfa_pkg::EXP_W-1:1]};
            state <= S_POW_CHK;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == S_IDLE);
  assign push      = (state == S_DONE) && out_free;
  assign push_data = res;

  assign mul_cmd.start = mul_start;
  assign mul_cmd.x     = mul_x;
  assign mul_cmd.y     = mul_y;

endmodule

/* rtl/core/prime_field_arithmetic_unit.sv */
// Channel  Dir  Fields                                    Accepted when
// req      in   kind, operand_a, operand_b, exponent      req.valid && req.ready
// rsp      out  result                                    rsp.valid && rsp.ready
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Add, subtract, negate: registered at acceptance, then pushed to the output register.
// Every field multiply runs on one bit-serial multiplier, so the cost of power
// grows with the bits and ones of the exponent; inverse (Fermat exponent p-2) runs
// as such a power, divide as one plus a final multiply. Synchronous reset, no clearing pass.
// A result waits in the output register while the next request is accepted.
module prime_field_arithmetic_unit (
  input  logic       clk,
  input  logic       rst,
  pfa_req_if.sink    req,
  pfa_rsp_if.source  rsp
);

  logic              idle;
  logic              accept;
  logic              out_free;
  logic              push;
  pfa_pkg::elem_t    push_data;
  pfa_pkg::req_t     req_data;
  pfa_pkg::mul_cmd_t mul_cmd;
  pfa_pkg::mul_sts_t mul_sts;
  logic              out_valid;
  pfa_pkg::elem_t    out_data;

  assign req.ready = idle;
  assign accept    = req.valid && idle;

  assign req_data.kind      = req.kind;
  assign req_data.operand_a = req.operand_a;
  assign req_data.operand_b = req.operand_b;
  assign req_data.exponent  = req.exponent;

  pfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_data  (req_data),
    .idle      (idle),
    .out_free  (out_free),
    .push      (push),
    .push_data (push_data),
    .mul_cmd   (mul_cmd),
    .mul_sts   (mul_sts)
  );

  pfa_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .cmd (mul_cmd),
    .sts (mul_sts)
  );

  // Hold the result until the sink takes it
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
      out_data  <= push_data;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.result = out_data;

  // Results are always reduced
  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.result < pfa_pkg::MODULUS))
    else $error("result not below modulus");

  // The multiplier is never busy while a new request can enter
  a_idle_mul_free: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !mul_sts.busy)
    else $error("multiplier busy while idle");

  // An accepted request closes the input for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("ready after accept");

  // A product only appears at the end of a running multiply
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    mul_sts.done |-> $past(mul_sts.busy))
    else $error("multiply done without run");

endmodule

/* verif/tb_prime_field_arithmetic_unit.sv */
module tb_prime_field_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pfa_pkg::*;

  localparam longint unsigned MOD = MODULUS_INT;
  localparam kind_t KIND_SPARE = kind_t'(7);
  localparam int RANDOM_REQUESTS = 750;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_COUNT = 2;

  typedef struct {
    req_t body;
    bit   drain_first;
  } stim_t;

  logic clk;
  logic rst;

  pfa_req_if req_ch ();
  pfa_rsp_if rsp_ch ();

  prime_field_arithmetic_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  stim_t request_queue[$];
  elem_t expected_field_values[$];
  stim_t staged_req;
  logic  req_accepted;
  int    requests_total;
  int    requests_taken;
  int    results_seen;
  int    error_count;
  int    idle_cycles;
  int    send_gap;
  int    stall_left;
  int    run_left;
  int    hold_left;
  int    holds_done;
  int    hold_at;

  // Modular product; operands stay below 2^30 so the product fits in 64 bits
  function automatic longint unsigned field_product(longint unsigned x, longint unsigned y);
    return (x * y) % MOD;
  endfunction

  // Extended Euclid, then fold the coefficient back into range
  function automatic longint unsigned field_inverse(longint unsigned x);
    longint a;
    longint b;
    longint u;
    longint v;
    longint q;
    longint t;
    a = longint'(x);
    b = longint'(MOD);
    u = 1;
    v = 0;
    while (b > 0) begin
      q = a / b;
      t = a - q * b;
      a = b;
      b = t;
      t = u - q * v;
      u = v;
      v = t;
    end
    u = u % longint'(MOD);
    if (u < 0) begin
      u = u + longint'(MOD);
    end
    return longint'(u);
  endfunction

  // Square and multiply over the exponent bits
  function automatic longint unsigned field_power(longint unsigned base, exp_t e);
    longint unsigned acc;
    longint unsigned m;
    exp_t rest;
    acc = 1 % MOD;
    m = base;
    rest = e;
    while (rest != 0) begin
      if (rest[0]) begin
        acc = field_product(acc, m);
      end
      m = field_product(m, m);
      rest = rest >> 1;
    end
    return acc;
  endfunction

  function automatic elem_t field_op_result(req_t r);
    longint unsigned a;
    longint unsigned b;
    longint unsigned v;
    a = longint'(r.operand_a) % MOD;
    b = longint'(r.operand_b) % MOD;
    case (r.kind)
      KIND_ADD: v = (a + b) % MOD;
      KIND_SUB: v = (a + MOD - b) % MOD;
      KIND_MUL: v = field_product(a, b);
      KIND_DIV: v = field_product(a, field_inverse(b));
      KIND_POW: v = field_power(a, r.exponent);
      KIND_INV: v = field_inverse(a);
      KIND_NEG: v = (MOD - a) % MOD;
      default:  v = 0;
    endcase
    return elem_t'(v);
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic elem_t pick_operand();
    case ($urandom_range(0, 9))
      6: begin
        case ($urandom_range(0, 3))
          0: return elem_t'(0);
          1: return elem_t'(1);
          2: return elem_t'(MOD - 1);
          default: return elem_t'(MOD - 2);
        endcase
      end
      7, 8: return elem_t'($urandom);
      9: return elem_t'($urandom_range(0, 15));
      default: return elem_t'($urandom_range(0, int'(MOD - 1)));
    endcase
  endfunction

  // Keep most exponents short so power stays cheap; a few span all 63 bits
  function automatic exp_t pick_exponent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return exp_t'($urandom_range(0, 65535));
    if (r < 85) return exp_t'($urandom);
    if (r < 95) return exp_t'({$urandom, $urandom});
    case ($urandom_range(0, 4))
      0: return '0;
      1: return exp_t'(1);
      2: return '1;
      3: return exp_t'(MOD - 2);
      default: return exp_t'(MOD - 1);
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 14) r.kind = KIND_ADD;
    else if (pick < 28) r.kind = KIND_SUB;
    else if (pick < 46) r.kind = KIND_MUL;
    else if (pick < 56) r.kind = KIND_DIV;
    else if (pick < 70) r.kind = KIND_POW;
    else if (pick < 80) r.kind = KIND_INV;
    else if (pick < 96) r.kind = KIND_NEG;
    else r.kind = KIND_SPARE;
    r.operand_a = pick_operand();
    r.operand_b = pick_operand();
    if (r.kind == KIND_POW) begin
      r.exponent = pick_exponent();
    end else begin
      r.exponent = exp_t'({$urandom, $urandom});
    end
    return r;
  endfunction

  task automatic queue_request(kind_t kind, elem_t a, elem_t b, exp_t e, bit drain);
    stim_t s;
    s.body.kind = kind;
    s.body.operand_a = a;
    s.body.operand_b = b;
    s.body.exponent = e;
    s.drain_first = drain;
    request_queue.push_back(s);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive requests from the queue at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!req_ch.valid || req_accepted) begin
      if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (request_queue.size() > 0 &&
                   (!request_queue[0].drain_first || expected_field_values.size() == 0)) begin
        staged_req = request_queue.pop_front();
        req_ch.kind      <= staged_req.body.kind;
        req_ch.operand_a <= staged_req.body.operand_a;
        req_ch.operand_b <= staged_req.body.operand_b;
        req_ch.exponent  <= staged_req.body.exponent;
        req_ch.valid     <= 1'b1;
        send_gap = pick_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Drive rsp ready: random stalls, ready runs, and long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      run_left = 0;
      hold_left = 0;
      holds_done = 0;
      hold_at = 60;
    end else begin
      if (holds_done < HOLD_COUNT && results_seen >= hold_at) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
        hold_at = hold_at + 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          stall_left = pick_gap();
          run_left = $urandom_range(0, 60);
        end
      end
    end
  end

  // Sample handshakes at the rising edge: predict, check, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      req_accepted <= 1'b0;
      idle_cycles = 0;
    end else begin
      req_accepted <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        expected_field_values.push_back(field_op_result('{
          kind: req_ch.kind, operand_a: req_ch.operand_a,
          operand_b: req_ch.operand_b, exponent: req_ch.exponent}));
        requests_taken++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (expected_field_values.size() == 0) begin
          error_count++;
          $display("%0t: result %0d with no request outstanding", $time, rsp_ch.result);
        end else if (rsp_ch.result !== expected_field_values[0]) begin
          error_count++;
          $display("%0t: result mismatch: expected %0d, actual %0d",
                   $time, expected_field_values[0], rsp_ch.result);
          void'(expected_field_values.pop_front());
        end else begin
          void'(expected_field_values.pop_front());
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
          $display("tb_prime_field_arithmetic_unit failed");
          $finish;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_ADD;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    req_ch.exponent = '0;
    rsp_ch.ready = 1'b0;
    requests_total = 0;
    requests_taken = 0;
    results_seen = 0;
    error_count = 0;

    // Directed: field extremes, every operation, unreduced operands, zero cases
    queue_request(KIND_ADD, elem_t'(MOD - 1), elem_t'(MOD - 1), '1, 1'b0);
    queue_request(KIND_ADD, '0, '0, '0, 1'b0);
    queue_request(KIND_ADD, elem_t'(MOD), '1, '1, 1'b0);
    queue_request(KIND_SUB, '0, elem_t'(1), '1, 1'b0);
    queue_request(KIND_SUB, elem_t'(MOD - 1), elem_t'(MOD - 1), '0, 1'b0);
    queue_request(KIND_SUB, '1, '0, '1, 1'b0);
    queue_request(KIND_MUL, elem_t'(MOD - 1), elem_t'(MOD - 1), '1, 1'b0);
    queue_request(KIND_MUL, '1, '1, '0, 1'b0);
    queue_request(KIND_DIV, elem_t'(12345), '0, '1, 1'b0);
    queue_request(KIND_DIV, elem_t'(MOD - 1), elem_t'(MOD - 1), '0, 1'b0);
    queue_request(KIND_DIV, elem_t'(12345), elem_t'(2), '1, 1'b0);
    queue_request(KIND_DIV, '1, elem_t'(MOD), '0, 1'b0);
    queue_request(KIND_POW, elem_t'(7), '1, '0, 1'b0);
    queue_request(KIND_POW, elem_t'(2), '0, '1, 1'b0);
    queue_request(KIND_POW, '0, '1, '0, 1'b0);
    queue_request(KIND_POW, '0, '0, exp_t'(5), 1'b0);
    queue_request(KIND_POW, elem_t'(MOD - 1), '0, exp_t'(MOD - 2), 1'b0);
    queue_request(KIND_POW, '1, '1, exp_t'(MOD - 1), 1'b0);
    queue_request(KIND_INV, '0, '1, '1, 1'b0);
    queue_request(KIND_INV, elem_t'(1), '0, '0, 1'b0);
    queue_request(KIND_INV, elem_t'(MOD - 1), '1, '1, 1'b0);
    queue_request(KIND_INV, elem_t'(MOD + 1), '0, '1, 1'b0);
    queue_request(KIND_NEG, '0, '1, '1, 1'b0);
    queue_request(KIND_NEG, '1, '0, '0, 1'b0);
    queue_request(KIND_SPARE, '1, '1, '1, 1'b0);

    // Random mix; some requests wait for the unit to drain first
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      staged_req.body = random_request();
      staged_req.drain_first = (i % 200 == 0);
      request_queue.push_back(staged_req);
    end
    requests_total = request_queue.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (requests_taken != requests_total || expected_field_values.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_prime_field_arithmetic_unit passed");
    end else begin
      $display("tb_prime_field_arithmetic_unit failed");
    end
    $finish;
  end

endmodule
